@@ rtl/integer_to_radix_digits_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for integer_to_radix_digits_top
// Shared shorthands for the concurrent checks on the block's ports.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_RADIX_DIGITS_TOP_MACROS_SVH
`define INTEGER_TO_RADIX_DIGITS_TOP_MACROS_SVH

// Overlapping implication, sampled on clock, quiet during reset.
`define I2RD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication checked in the cycle after the antecedent.
`define I2RD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/i2rd_pkg.sv @@
// ----------------------------------------------------------------------------
// i2rd_pkg
// Types, sizes and character codes shared by the radix conversion block.
// ----------------------------------------------------------------------------
package i2rd_pkg;

   // Width of the converted integer; a multiple of STEP_BITS.
   localparam int VALUE_BITS     = 32;
   // Quotient bits resolved per cycle of the divider.
   localparam int STEP_BITS      = 8;
   localparam int DIV_CYCLES     = VALUE_BITS / STEP_BITS;
   localparam int STEP_CNT_BITS  = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
   localparam int DIG_CNT_BITS   = $clog2(VALUE_BITS + 1);
   localparam int DIG_IDX_BITS   = $clog2(VALUE_BITS);

   localparam int RADIX_BITS     = 5;
   localparam int DIGIT_BITS     = 4;
   localparam int CHAR_BITS      = 7;
   localparam int REQ_DATA_BITS  = ((VALUE_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS  = 8;

   localparam logic [RADIX_BITS-1:0] RADIX_RESET = 5'd10;
   localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 5'd2;
   localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 5'd16;

   localparam logic [CHAR_BITS-1:0] MINUS_CODE = 7'd45;
   localparam logic [CHAR_BITS-1:0] DIGIT_CODES [16] = '{
      7'd48, 7'd49, 7'd50, 7'd51, 7'd52, 7'd53, 7'd54, 7'd55,
      7'd56, 7'd57, 7'd65, 7'd66, 7'd67, 7'd68, 7'd69, 7'd70
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_CHECK,
      ST_SIGN,
      ST_DIGITS
   } i2rd_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic div_step;
      logic div_done;
      logic emit_sign;
      logic emit_digit;
   } i2rd_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic mag_zero;
      logic neg;
      logic out_free;
      logic last_digit;
   } i2rd_sts_type;

endpackage

@@ rtl/i2rd_ctrl.sv @@
// ----------------------------------------------------------------------------
// i2rd_ctrl
// Sequencer: accepts an item, runs one division per digit, then emits text.
// ----------------------------------------------------------------------------
module i2rd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  i2rd_pkg::i2rd_sts_type sts,
   output i2rd_pkg::i2rd_cmd_type cmd
);
   import i2rd_pkg::*;

   i2rd_state_type             state_ff, state_in;
   logic [STEP_CNT_BITS-1:0]   step_cnt_ff, step_cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         step_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         step_cnt_ff <= step_cnt_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      step_cnt_in = step_cnt_ff;
      cmd         = '0;
      req_tready  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load    = 1'b1;
               step_cnt_in = '0;
               state_in    = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (step_cnt_ff == STEP_CNT_BITS'(DIV_CYCLES - 1)) begin
               cmd.div_done = 1'b1;
               step_cnt_in  = '0;
               state_in     = ST_CHECK;
            end else begin
               step_cnt_in = step_cnt_ff + 1'b1;
            end
         end
         ST_CHECK: begin
            // The quotient left by the last division decides whether more digits follow.
            if (!sts.mag_zero) begin
               state_in = ST_DIVIDE;
            end else if (sts.neg) begin
               state_in = ST_SIGN;
            end else begin
               state_in = ST_DIGITS;
            end
         end
         ST_SIGN: begin
            if (sts.out_free) begin
               cmd.emit_sign = 1'b1;
               state_in      = ST_DIGITS;
            end
         end
         ST_DIGITS: begin
            if (sts.out_free) begin
               cmd.emit_digit = 1'b1;
               if (sts.last_digit) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/i2rd_dpath.sv @@
// ----------------------------------------------------------------------------
// i2rd_dpath
// Magnitude, radix register, shift-subtract divider, digit stack, output stage.
// ----------------------------------------------------------------------------
module i2rd_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [i2rd_pkg::VALUE_BITS-1:0]      value,
   input  logic                                 csr_valid,
   input  logic [i2rd_pkg::RADIX_BITS-1:0]      csr_data,
   input  i2rd_pkg::i2rd_cmd_type               cmd,
   output i2rd_pkg::i2rd_sts_type               sts,
   input  logic                                 rsp_tready,
   output logic                                 rsp_tvalid,
   output logic [i2rd_pkg::CHAR_BITS-1:0]       rsp_char,
   output logic                                 rsp_tlast
);
   import i2rd_pkg::*;

   logic [RADIX_BITS-1:0]   radix_ff, radix_in;
   logic [VALUE_BITS-1:0]   mag_ff, mag_in;
   logic [DIGIT_BITS-1:0]   rem_ff, rem_in;
   logic                    neg_ff, neg_in;
   logic [DIG_CNT_BITS-1:0] ndig_ff, ndig_in;
   logic [DIGIT_BITS-1:0]   digit_ff [VALUE_BITS];
   logic [DIG_IDX_BITS-1:0] rd_idx;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CHAR_BITS-1:0]    rsp_char_ff, rsp_char_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic [VALUE_BITS-1:0]   quo_step;
   logic [DIGIT_BITS-1:0]   rem_step;
   logic                    out_free;

   // Writes are clamped into 2..16 as they are stored.
   always_comb begin
      radix_in = radix_ff;
      if (csr_valid) begin
         if (csr_data < RADIX_MIN) begin
            radix_in = RADIX_MIN;
         end else if (csr_data > RADIX_MAX) begin
            radix_in = RADIX_MAX;
         end else begin
            radix_in = csr_data;
         end
      end
   end

   // STEP_BITS restoring steps per cycle; the remainder always stays below the radix,
   // and quotient bits shift in where dividend bits leave.
   always_comb begin
      logic [VALUE_BITS-1:0] d;
      logic [DIGIT_BITS-1:0] r;
      logic [RADIX_BITS-1:0] t;
      logic                  q;
      d = mag_ff;
      r = rem_ff;
      for (int i = 0; i < STEP_BITS; i++) begin
         t = {r, d[VALUE_BITS-1]};
         q = (t >= radix_ff);
         if (q) begin
            t = t - radix_ff;
         end
         r = t[DIGIT_BITS-1:0];
         d = {d[VALUE_BITS-2:0], q};
      end
      quo_step = d;
      rem_step = r;
   end

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign rd_idx   = DIG_IDX_BITS'(ndig_ff - 1'b1);

   always_comb begin
      mag_in       = mag_ff;
      rem_in       = rem_ff;
      neg_in       = neg_ff;
      ndig_in      = ndig_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.load) begin
         neg_in  = value[VALUE_BITS-1];
         mag_in  = value[VALUE_BITS-1] ? (~value + 1'b1) : value;
         rem_in  = '0;
         ndig_in = '0;
      end
      if (cmd.div_step) begin
         mag_in = quo_step;
         rem_in = rem_step;
      end
      if (cmd.div_done) begin
         rem_in  = '0;
         ndig_in = ndig_ff + 1'b1;
      end
      if (cmd.emit_sign) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = MINUS_CODE;
         rsp_last_in  = 1'b0;
      end
      if (cmd.emit_digit) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = DIGIT_CODES[digit_ff[rd_idx]];
         rsp_last_in  = (ndig_ff == DIG_CNT_BITS'(1));
         ndig_in      = ndig_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff     <= RADIX_RESET;
         ndig_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         radix_ff     <= radix_in;
         ndig_ff      <= ndig_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      rem_ff      <= rem_in;
      neg_ff      <= neg_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Digits are stacked least significant first and popped in reverse order.
   always_ff @(posedge clock) begin
      if (cmd.div_done) begin
         digit_ff[ndig_ff[DIG_IDX_BITS-1:0]] <= rem_step;
      end
   end

   assign sts.mag_zero   = (mag_ff == '0);
   assign sts.neg        = neg_ff;
   assign sts.out_free   = out_free;
   assign sts.last_digit = (ndig_ff == DIG_CNT_BITS'(1));

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_char   = rsp_char_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

@@ rtl/integer_to_radix_digits_top.sv @@
// ----------------------------------------------------------------------------
// integer_to_radix_digits_top
// Converts a signed integer to ASCII text in radix 2..16, one character per item.
// ----------------------------------------------------------------------------
// Channel  Direction  Payload
// req_     in         tdata[31:0] value (signed), tdata holds nothing else
// rsp_     out        tdata[6:0] char_code, tdata[7] zero; tlast last_char
// csr_     in         data[4:0] radix, clamped to 2..16, reset value 10
//
// Each digit takes one full pass of the divider followed by a check of the quotient;
// once the quotient is zero, the sign (for a negative value) and then the digits
// are emitted, each as the output register frees up. The divider resolves
// 8 quotient bits per cycle. The next item is accepted once the last character has
// entered the output register. Reset is synchronous; it clears control state and
// returns the radix to 10.
// ----------------------------------------------------------------------------
module integer_to_radix_digits_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [i2rd_pkg::REQ_DATA_BITS-1:0]     req_tdata,   // [31:0] value
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [i2rd_pkg::RSP_DATA_BITS-1:0]     rsp_tdata,   // [6:0] char_code
   output logic                                   rsp_tlast,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [i2rd_pkg::RADIX_BITS-1:0]        csr_data
);
   import i2rd_pkg::*;

   i2rd_cmd_type         cmd;
   i2rd_sts_type         sts;
   logic [CHAR_BITS-1:0] rsp_char;

   assign csr_ready = 1'b1;

   i2rd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   i2rd_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .value      (req_tdata[VALUE_BITS-1:0]),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_char   (rsp_char),
      .rsp_tlast  (rsp_tlast)
   );

   assign rsp_tdata = {{(RSP_DATA_BITS - CHAR_BITS){1'b0}}, rsp_char};

endmodule

@@ rtl/i2rd_checker.sv @@
// ----------------------------------------------------------------------------
// i2rd_checker
// Port-level checks on the radix conversion block, bound to its top level.
// ----------------------------------------------------------------------------
`include "integer_to_radix_digits_top_macros.svh"

module i2rd_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [i2rd_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input logic                               rsp_tlast
);
   import i2rd_pkg::*;

   logic rsp_stall;
   logic rsp_is_minus;
   logic rsp_code_ok;
   logic req_accept;

   assign rsp_stall    = rsp_tvalid && !rsp_tready;
   assign rsp_is_minus = (rsp_tdata == RSP_DATA_BITS'(MINUS_CODE));
   assign rsp_code_ok  = rsp_is_minus
                         || ((rsp_tdata >= 8'd48) && (rsp_tdata <= 8'd57))
                         || ((rsp_tdata >= 8'd65) && (rsp_tdata <= 8'd70));
   assign req_accept   = req_tvalid && req_tready;

   // An item is converted over several cycles, so input is closed right after it.
   `I2RD_ASSERT_NEXT(a_busy_after_accept, req_accept, !req_tready, "accepted twice in a row")
   // Every character is a minus sign or a digit of 0-9, A-F.
   `I2RD_ASSERT_NOW(a_legal_code, rsp_tvalid, rsp_code_ok, "illegal character code")
   // The sign always precedes digits, so it never ends the text.
   `I2RD_ASSERT_NOW(a_minus_not_last, rsp_tvalid && rsp_is_minus, !rsp_tlast, "minus marked last")
   // A stalled character is not withdrawn.
   `I2RD_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_tvalid, "rsp item dropped while stalled")

endmodule

bind integer_to_radix_digits_top i2rd_checker u_i2rd_checker (.*);

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb: integer to radix digits testbench
// Streams signed integers into the block across many radix settings and checks
// that the ASCII text it returns matches a local model, character by character.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import i2rd_pkg::*;

   localparam int                  CYCLE_LIMIT = 1000000;
   localparam int                  DRAIN_CYCLES = 200;
   localparam logic [CHAR_BITS-1:0] CODE_MINUS = 7'd45;
   localparam logic [CHAR_BITS-1:0] CODE_ZERO = 7'd48;
   localparam logic [CHAR_BITS-1:0] CODE_LETTER_A = 7'd65;
   localparam logic [RADIX_BITS-1:0] BASE_LOW = 5'd2;
   localparam logic [RADIX_BITS-1:0] BASE_HIGH = 5'd16;
   localparam logic [RADIX_BITS-1:0] BASE_DECIMAL = 5'd10;

   typedef enum int {
      RX_ALWAYS,
      RX_RANDOM,
      RX_PERIODIC
   } rx_mode_type;

   typedef struct {
      logic [CHAR_BITS-1:0] code;
      logic                 last;
   } text_char_type;

   logic                       clock;
   logic                       reset;
   logic                       req_tvalid;
   logic                       req_tready;
   logic [REQ_DATA_BITS-1:0]   req_tdata;   // [31:0] value
   logic                       rsp_tvalid;
   logic                       rsp_tready;
   logic [RSP_DATA_BITS-1:0]   rsp_tdata;   // [6:0] char_code, [7] zero
   logic                       rsp_tlast;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [RADIX_BITS-1:0]      csr_data;

   text_char_type              pending_chars[$];
   logic [RADIX_BITS-1:0]      radix_shadow;
   int                         error_count;
   int                         cycle_count;
   int                         burst_left;
   rx_mode_type                rx_mode;
   int                         rx_mode_left;

   integer_to_radix_digits_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic logic [RADIX_BITS-1:0] clamp_base(input logic [RADIX_BITS-1:0] raw);
      if (raw < BASE_LOW) begin
         return BASE_LOW;
      end
      if (raw > BASE_HIGH) begin
         return BASE_HIGH;
      end
      return raw;
   endfunction

   // Builds the expected text of one value: optional sign, then digits from
   // the most significant one down, with the mark on the final character.
   task automatic predict_text(input logic [31:0] value, input logic [RADIX_BITS-1:0] base);
      logic [31:0]   mag;
      logic [31:0]   base_wide;
      logic [3:0]    digits[$];
      text_char_type ch;
      int            i;
      mag = value[31] ? (~value + 32'd1) : value;
      base_wide = {27'd0, base};
      do begin
         digits.push_back(4'(mag % base_wide));
         mag = mag / base_wide;
      end while (mag != 32'd0);
      if (value[31]) begin
         ch.code = CODE_MINUS;
         ch.last = 1'b0;
         pending_chars.push_back(ch);
      end
      for (i = digits.size() - 1; i >= 0; i--) begin
         if (digits[i] < 4'd10) begin
            ch.code = CODE_ZERO + 7'(digits[i]);
         end else begin
            ch.code = CODE_LETTER_A + 7'(digits[i]) - 7'd10;
         end
         ch.last = (i == 0);
         pending_chars.push_back(ch);
      end
   endtask

   // Sends one value; the sender sometimes idles between bursts of random length.
   task automatic send_value(input logic [31:0] value);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_text(value, radix_shadow);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_chars.size() != 0) @(posedge clock);
   endtask

   // The register is only written once every character has come back.
   task automatic write_radix(input logic [RADIX_BITS-1:0] raw);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= raw;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      radix_shadow = clamp_base(raw);
   endtask

   function automatic logic [31:0] random_value();
      logic [31:0] v;
      case ($urandom_range(0, 5))
         0: v = $urandom_range(0, 40);
         1: v = -$urandom_range(1, 40);
         2: v = $urandom >> $urandom_range(0, 31);
         3: v = -($urandom >> $urandom_range(0, 31));
         4: v = ($urandom_range(0, 1) == 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // Each returned character is checked against the oldest one predicted.
   always @(posedge clock) begin
      text_char_type exp_ch;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_chars.size() == 0) begin
            $error("unexpected character 0x%0h last %0b", rsp_tdata[CHAR_BITS-1:0], rsp_tlast);
            error_count++;
         end else begin
            exp_ch = pending_chars.pop_front();
            if (rsp_tdata[CHAR_BITS-1:0] !== exp_ch.code) begin
               $error("char_code: expected 0x%0h, actual 0x%0h", exp_ch.code,
                      rsp_tdata[CHAR_BITS-1:0]);
               error_count++;
            end
            if (rsp_tlast !== exp_ch.last) begin
               $error("last_char: expected %0b, actual %0b", exp_ch.last, rsp_tlast);
               error_count++;
            end
         end
      end
      if (rx_mode_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 2));
         rx_mode_left = $urandom_range(64, 256);
      end else begin
         rx_mode_left--;
      end
      case (rx_mode)
         RX_ALWAYS:   rsp_tready <= 1'b1;
         RX_RANDOM:   rsp_tready <= ($urandom_range(0, 9) < 6);
         default:     rsp_tready <= ((cycle_count % 5) > 1);
      endcase
   end

   task automatic test_decimal_after_reset();
      send_value(32'd0);
      send_value(32'd1);
      send_value(32'hFFFF_FFFF);
      send_value(32'h7FFF_FFFF);
      send_value(32'h8000_0000);
      send_value(32'd10);
      send_value(-32'd1000);
      send_value(32'd9);
   endtask

   task automatic test_radix_extremes();
      write_radix(BASE_LOW);
      send_value(32'd0);
      send_value(32'h7FFF_FFFF);
      send_value(32'h8000_0000);
      send_value(32'hFFFF_FFFF);
      send_value(32'h5555_AAAA);
      write_radix(BASE_HIGH);
      send_value(32'h0123_4567);
      send_value(32'h89AB_CDEF);
      send_value(32'h8000_0000);
      send_value(32'h7FFF_FFFF);
      send_value(32'd15);
      send_value(32'd0);
   endtask

   task automatic test_radix_clamp();
      write_radix(5'd0);
      send_value(32'd5);
      send_value(-32'd3);
      write_radix(5'd1);
      send_value(32'd6);
      write_radix(5'd17);
      send_value(32'd255);
      write_radix(5'd31);
      send_value(-32'd256);
      write_radix(BASE_DECIMAL);
      send_value(32'd0);
   endtask

   task automatic test_random_values();
      logic [RADIX_BITS-1:0] raw;
      int phase;
      int n;
      for (phase = 0; phase < 9; phase++) begin
         case (phase)
            0:       raw = BASE_LOW;
            1:       raw = BASE_HIGH;
            2:       raw = 5'd3;
            default: raw = 5'($urandom_range(0, 31));
         endcase
         write_radix(raw);
         for (n = 0; n < 50; n++) begin
            send_value(random_value());
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_data = '0;
      error_count = 0;
      cycle_count = 0;
      burst_left = 0;
      rx_mode = RX_ALWAYS;
      rx_mode_left = 0;
      radix_shadow = BASE_DECIMAL;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_decimal_after_reset();
      test_radix_extremes();
      test_radix_clamp();
      test_random_values();

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
